>>> sv/spcp_pkg.sv
// shared widths, constants and types for the segment pair closest point core
`timescale 1ns / 1ps
`default_nettype none
package spcp_pkg;

    localparam int CW    = 16;           // coordinate width
    localparam int FB    = 16;           // fraction bits of s and t
    localparam int QB    = FB + 1;       // quotient bits, covers one
    localparam int DW_D  = CW + 1;       // coordinate difference
    localparam int PW    = 2 * DW_D;     // one product of differences
    localparam int DOT_W = PW + 1;       // dot product of differences
    localparam int BIG_W = 2 * DOT_W + 1;
    localparam int EPS_W = 16;
    localparam int DIST_W = 2 * CW + 2;

    localparam logic [QB-1:0] PONE = {1'b1, {FB{1'b0}}};

    typedef logic [2:0][CW-1:0]   cvec_t;
    typedef logic [2:0][DW_D-1:0] dvec_t;

    typedef struct packed {
        cvec_t                   as;
        cvec_t                   bs;
        dvec_t                   d1;
        dvec_t                   d2;
        logic signed [DOT_W-1:0] a;
        logic signed [DOT_W-1:0] b;
        logic signed [DOT_W-1:0] c;
        logic signed [DOT_W-1:0] e;
        logic signed [DOT_W-1:0] f;
        logic                    dega;
        logic                    dege;
    } item_t;

endpackage
`default_nettype wire

>>> sv/spcp_mul.sv
// two stage signed multiplier, second operand split in two halves
`timescale 1ns / 1ps
`default_nettype none
module spcp_mul #(
    parameter int W = 35
) (
    input  wire logic                  clk,
    input  wire logic signed [W-1:0]   x,
    input  wire logic signed [W-1:0]   y,
    output logic signed [2*W-1:0]      p
);

    localparam int LO = (W + 1) / 2;
    localparam int HI = W - LO;

    logic signed [W+LO:0]     plo_reg, plo_next;
    logic signed [W+HI-1:0]   phi_reg, phi_next;
    logic signed [2*W-1:0]    p_reg, p_next;
    logic signed [2*W-1:0]    ext_lo, ext_hi;

    always_comb
    begin
        plo_next = x * $signed({1'b0, y[LO-1:0]});
        phi_next = x * $signed(y[W-1:LO]);
        ext_lo   = (2*W)'(plo_reg);
        ext_hi   = (2*W)'(phi_reg);
        p_next   = (ext_hi <<< LO) + ext_lo;
    end

    always_ff @(posedge clk)
    begin
        plo_reg <= plo_next;
        phi_reg <= phi_next;
        p_reg   <= p_next;
    end

    assign p = p_reg;

endmodule
`default_nettype wire

>>> sv/spcp_div.sv
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
`default_nettype none
module spcp_div #(
    parameter int DW = 35,
    parameter int SW = 1
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    input  wire logic [DW+spcp_pkg::QB-1:0]  in_x,
    input  wire logic [DW-1:0]               in_d,
    input  wire logic [SW-1:0]               in_tag,
    output logic                             out_valid,
    output logic [spcp_pkg::QB-1:0]          out_q,
    output logic [SW-1:0]                    out_tag
);

    localparam int QB = spcp_pkg::QB;
    localparam int XW = DW + QB;

    logic [XW-1:0] x_reg   [QB];
    logic [DW-1:0] d_reg   [QB];
    logic [QB-1:0] q_reg   [QB];
    logic [SW-1:0] tag_reg [QB];
    logic [QB-1:0] v_reg;

    genvar k;
    for (k = 0; k < QB; k++)
    begin : g_stage
        localparam int SH = QB - 1 - k;
        logic [XW-1:0] x_cur, x_next, sub;
        logic [DW-1:0] d_cur;
        logic [QB-1:0] q_cur, q_next;
        logic [SW-1:0] tag_cur;
        logic          v_cur;

        if (k == 0)
        begin : g_first
            assign x_cur   = in_x;
            assign d_cur   = in_d;
            assign q_cur   = '0;
            assign tag_cur = in_tag;
            assign v_cur   = in_valid;
        end
        else
        begin : g_rest
            assign x_cur   = x_reg[k-1];
            assign d_cur   = d_reg[k-1];
            assign q_cur   = q_reg[k-1];
            assign tag_cur = tag_reg[k-1];
            assign v_cur   = v_reg[k-1];
        end

        always_comb
        begin
            sub = XW'(d_cur) << SH;
            if (x_cur >= sub)
            begin
                x_next = x_cur - sub;
                q_next = {q_cur[QB-2:0], 1'b1};
            end
            else
            begin
                x_next = x_cur;
                q_next = {q_cur[QB-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k] <= 1'b0;
            else
                v_reg[k] <= v_cur;
        end

        always_ff @(posedge clk)
        begin
            x_reg[k]   <= x_next;
            d_reg[k]   <= d_cur;
            q_reg[k]   <= q_next;
            tag_reg[k] <= tag_cur;
        end
    end

    assign out_valid = v_reg[QB-1];
    assign out_q     = q_reg[QB-1];
    assign out_tag   = tag_reg[QB-1];

endmodule
`default_nettype wire

>>> sv/spcp_front.sv
// front end: directions, dot products and degenerate tests
`timescale 1ns / 1ps
`default_nettype none
module spcp_front (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    input  wire spcp_pkg::cvec_t             as_in,
    input  wire spcp_pkg::cvec_t             ae_in,
    input  wire spcp_pkg::cvec_t             bs_in,
    input  wire spcp_pkg::cvec_t             be_in,
    input  wire logic [spcp_pkg::EPS_W-1:0]  eps,
    output logic                             out_valid,
    output spcp_pkg::item_t                  out_item
);

    localparam int DW_D  = spcp_pkg::DW_D;
    localparam int PW    = spcp_pkg::PW;
    localparam int DOT_W = spcp_pkg::DOT_W;
    localparam int EPS_W = spcp_pkg::EPS_W;

    logic [3:0] valid_reg, valid_next;

    spcp_pkg::cvec_t as1_reg, ae1_reg, bs1_reg, be1_reg;
    spcp_pkg::cvec_t as2_reg, bs2_reg, as3_reg, bs3_reg;
    spcp_pkg::dvec_t d1_reg, d2_reg, r_reg, d1_next, d2_next, r_next;
    spcp_pkg::dvec_t d1b_reg, d2b_reg;

    logic signed [PW-1:0] pa_reg [3], pe_reg [3], pb_reg [3], pc_reg [3], pf_reg [3];
    logic signed [PW-1:0] pa_next [3], pe_next [3], pb_next [3], pc_next [3], pf_next [3];

    spcp_pkg::item_t item_reg, item_next;
    logic signed [DOT_W-1:0] eps_ext;

    assign valid_next = {valid_reg[2:0], in_valid};
    assign eps_ext    = $signed({{(DOT_W-EPS_W){1'b0}}, eps});

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            d1_next[i] = DW_D'($signed(ae1_reg[i])) - DW_D'($signed(as1_reg[i]));
            d2_next[i] = DW_D'($signed(be1_reg[i])) - DW_D'($signed(bs1_reg[i]));
            r_next[i]  = DW_D'($signed(as1_reg[i])) - DW_D'($signed(bs1_reg[i]));
        end
        for (int i = 0; i < 3; i++)
        begin
            pa_next[i] = $signed(d1_reg[i]) * $signed(d1_reg[i]);
            pe_next[i] = $signed(d2_reg[i]) * $signed(d2_reg[i]);
            pb_next[i] = $signed(d1_reg[i]) * $signed(d2_reg[i]);
            pc_next[i] = $signed(d1_reg[i]) * $signed(r_reg[i]);
            pf_next[i] = $signed(d2_reg[i]) * $signed(r_reg[i]);
        end
        item_next.as = as3_reg;
        item_next.bs = bs3_reg;
        item_next.d1 = d1b_reg;
        item_next.d2 = d2b_reg;
        item_next.a  = DOT_W'(pa_reg[0]) + DOT_W'(pa_reg[1]) + DOT_W'(pa_reg[2]);
        item_next.e  = DOT_W'(pe_reg[0]) + DOT_W'(pe_reg[1]) + DOT_W'(pe_reg[2]);
        item_next.b  = DOT_W'(pb_reg[0]) + DOT_W'(pb_reg[1]) + DOT_W'(pb_reg[2]);
        item_next.c  = DOT_W'(pc_reg[0]) + DOT_W'(pc_reg[1]) + DOT_W'(pc_reg[2]);
        item_next.f  = DOT_W'(pf_reg[0]) + DOT_W'(pf_reg[1]) + DOT_W'(pf_reg[2]);
        item_next.dega = (item_next.a <= eps_ext);
        item_next.dege = (item_next.e <= eps_ext);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        as1_reg <= as_in;
        ae1_reg <= ae_in;
        bs1_reg <= bs_in;
        be1_reg <= be_in;
        as2_reg <= as1_reg;
        bs2_reg <= bs1_reg;
        d1_reg  <= d1_next;
        d2_reg  <= d2_next;
        r_reg   <= r_next;
        as3_reg <= as2_reg;
        bs3_reg <= bs2_reg;
        d1b_reg <= d1_reg;
        d2b_reg <= d2_reg;
        for (int i = 0; i < 3; i++)
        begin
            pa_reg[i] <= pa_next[i];
            pe_reg[i] <= pe_next[i];
            pb_reg[i] <= pb_next[i];
            pc_reg[i] <= pc_next[i];
            pf_reg[i] <= pf_next[i];
        end
        item_reg <= item_next;
    end

    assign out_valid = valid_reg[3];
    assign out_item  = item_reg;

endmodule
`default_nettype wire

>>> sv/spcp_point.sv
// back end: closest points, rounding, squared distance and hit flag
`timescale 1ns / 1ps
`default_nettype none
module spcp_point (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    input  wire spcp_pkg::item_t              in_item,
    input  wire logic [spcp_pkg::QB-1:0]      in_s,
    input  wire logic [spcp_pkg::QB-1:0]      in_t,
    input  wire logic [spcp_pkg::EPS_W-1:0]   eps,
    output logic                              done,
    output logic [spcp_pkg::QB-1:0]           s_param,
    output logic [spcp_pkg::QB-1:0]           t_param,
    output spcp_pkg::cvec_t                   near_a,
    output spcp_pkg::cvec_t                   near_b,
    output logic [spcp_pkg::DIST_W-1:0]       dist_sq,
    output logic                              hit
);

    localparam int CW     = spcp_pkg::CW;
    localparam int FB     = spcp_pkg::FB;
    localparam int QB     = spcp_pkg::QB;
    localparam int DW_D   = spcp_pkg::DW_D;
    localparam int DIST_W = spcp_pkg::DIST_W;
    localparam int MW     = DW_D + QB + 1;
    localparam int VW     = CW + FB + 4;
    localparam logic signed [VW-1:0] HALF = VW'(1) << (FB - 1);

    logic [4:0] valid_reg, valid_next;
    logic [QB-1:0] s_reg [5], t_reg [5];

    spcp_pkg::cvec_t as_reg, bs_reg;
    logic signed [MW-1:0] pra_reg [3], prb_reg [3], pra_next [3], prb_next [3];
    logic signed [VW-1:0] va [3], vb [3];
    spcp_pkg::cvec_t pa_reg, pb_reg, pa_next, pb_next;
    spcp_pkg::cvec_t pa3_reg, pb3_reg, pa4_reg, pb4_reg, pa5_reg, pb5_reg;
    logic signed [CW:0] df_reg [3], df_next [3];
    logic [DIST_W-1:0] sq_reg [3], sq_next [3];
    logic [DIST_W-1:0] dist_reg, dist_next;
    logic hit_reg, hit_next;

    assign valid_next = {valid_reg[3:0], in_valid};

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            pra_next[i] = $signed(in_item.d1[i]) * $signed({1'b0, in_s});
            prb_next[i] = $signed(in_item.d2[i]) * $signed({1'b0, in_t});
            // round half up is a floor after adding one half
            va[i] = (VW'($signed(as_reg[i])) <<< FB) + VW'(pra_reg[i]) + HALF;
            vb[i] = (VW'($signed(bs_reg[i])) <<< FB) + VW'(prb_reg[i]) + HALF;
            pa_next[i] = va[i][FB+CW-1:FB];
            pb_next[i] = vb[i][FB+CW-1:FB];
            df_next[i] = (CW+1)'($signed(pa_reg[i])) - (CW+1)'($signed(pb_reg[i]));
            sq_next[i] = DIST_W'(df_reg[i] * df_reg[i]);
        end
        dist_next = sq_reg[0] + sq_reg[1] + sq_reg[2];
        hit_next  = (dist_next <= DIST_W'(eps));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        s_reg[0] <= in_s;
        t_reg[0] <= in_t;
        for (int k = 1; k < 5; k++)
        begin
            s_reg[k] <= s_reg[k-1];
            t_reg[k] <= t_reg[k-1];
        end
        as_reg <= in_item.as;
        bs_reg <= in_item.bs;
        for (int i = 0; i < 3; i++)
        begin
            pra_reg[i] <= pra_next[i];
            prb_reg[i] <= prb_next[i];
            df_reg[i]  <= df_next[i];
            sq_reg[i]  <= sq_next[i];
        end
        pa_reg   <= pa_next;
        pb_reg   <= pb_next;
        pa3_reg  <= pa_reg;
        pb3_reg  <= pb_reg;
        pa4_reg  <= pa3_reg;
        pb4_reg  <= pb3_reg;
        pa5_reg  <= pa4_reg;
        pb5_reg  <= pb4_reg;
        dist_reg <= dist_next;
        hit_reg  <= hit_next;
    end

    assign done    = valid_reg[4];
    assign s_param = s_reg[4];
    assign t_param = t_reg[4];
    assign near_a  = pa5_reg;
    assign near_b  = pb5_reg;
    assign dist_sq = dist_reg;
    assign hit     = hit_reg;

endmodule
`default_nettype wire

>>> sv/segment_pair_closest_points_core.sv
// top level: closest points between two 3d segments, fully pipelined
// from the start edge to the done strobe the path runs through 2 * 17 divider stages
// throughput: one item per cycle, busy stays low, set by the pipelined dividers
// results come out on a one cycle strobe; the receiver cannot stall
// reset clears the valid bits and sets eps_reg to zero
`timescale 1ns / 1ps
`default_nettype none
module segment_pair_closest_points_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [15:0]        cfg_data,
    input  wire logic signed [15:0] a_start_x,
    input  wire logic signed [15:0] a_start_y,
    input  wire logic signed [15:0] a_start_z,
    input  wire logic signed [15:0] a_end_x,
    input  wire logic signed [15:0] a_end_y,
    input  wire logic signed [15:0] a_end_z,
    input  wire logic signed [15:0] b_start_x,
    input  wire logic signed [15:0] b_start_y,
    input  wire logic signed [15:0] b_start_z,
    input  wire logic signed [15:0] b_end_x,
    input  wire logic signed [15:0] b_end_y,
    input  wire logic signed [15:0] b_end_z,
    output logic                    done,
    output logic [16:0]             s_param,
    output logic [16:0]             t_param,
    output logic signed [15:0]      near_a_x,
    output logic signed [15:0]      near_a_y,
    output logic signed [15:0]      near_a_z,
    output logic signed [15:0]      near_b_x,
    output logic signed [15:0]      near_b_y,
    output logic signed [15:0]      near_b_z,
    output logic [33:0]             dist_sq,
    output logic                    hit
);

    localparam int FB    = spcp_pkg::FB;
    localparam int QB    = spcp_pkg::QB;
    localparam int DOT_W = spcp_pkg::DOT_W;
    localparam int BIG_W = spcp_pkg::BIG_W;
    localparam int EPS_W = spcp_pkg::EPS_W;
    localparam int TN_W  = DOT_W + FB + 3;
    localparam int NS_W  = DOT_W + 1;
    localparam int XW1   = BIG_W + QB;
    localparam int XW2   = DOT_W + QB;
    localparam int LAT   = 15 + 2 * QB;

    typedef struct packed {
        spcp_pkg::item_t item;
        logic            zero;
        logic            one;
    } d1_tag_t;

    typedef struct packed {
        spcp_pkg::item_t item;
        logic [QB-1:0]   s;
        logic            lt;
        logic            gt;
        logic            zero;
        logic            one;
    } dt_tag_t;

    typedef struct packed {
        logic zero;
        logic one;
    } ds_tag_t;

    logic [EPS_W-1:0] eps_reg;

    spcp_pkg::cvec_t as_in, ae_in, bs_in, be_in;
    logic            f_valid;
    spcp_pkg::item_t f_item;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            eps_reg <= '0;
        else if (cfg_valid && cfg_ready)
            eps_reg <= cfg_data;
    end

    assign as_in = {a_start_z, a_start_y, a_start_x};
    assign ae_in = {a_end_z, a_end_y, a_end_x};
    assign bs_in = {b_start_z, b_start_y, b_start_x};
    assign be_in = {b_end_z, b_end_y, b_end_x};

    spcp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .as_in     (as_in),
        .ae_in     (ae_in),
        .bs_in     (bs_in),
        .be_in     (be_in),
        .eps       (eps_reg),
        .out_valid (f_valid),
        .out_item  (f_item)
    );

    // denominator and numerator of the unclamped s
    logic signed [2*DOT_W-1:0] p_ae, p_bb, p_bf, p_ce;

    spcp_mul #(.W(DOT_W)) u_mul_ae (.clk(clk), .x(f_item.a), .y(f_item.e), .p(p_ae));
    spcp_mul #(.W(DOT_W)) u_mul_bb (.clk(clk), .x(f_item.b), .y(f_item.b), .p(p_bb));
    spcp_mul #(.W(DOT_W)) u_mul_bf (.clk(clk), .x(f_item.b), .y(f_item.f), .p(p_bf));
    spcp_mul #(.W(DOT_W)) u_mul_ce (.clk(clk), .x(f_item.c), .y(f_item.e), .p(p_ce));

    logic [2:0]      mv_reg;
    spcp_pkg::item_t m1_item_reg, m2_item_reg, q_item_reg;
    logic signed [BIG_W-1:0] den_reg, num_reg, den_next, num_next;

    assign den_next = BIG_W'(p_ae) - BIG_W'(p_bb);
    assign num_next = BIG_W'(p_bf) - BIG_W'(p_ce);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mv_reg <= '0;
        else
            mv_reg <= {mv_reg[1:0], f_valid};
    end

    always_ff @(posedge clk)
    begin
        m1_item_reg <= f_item;
        m2_item_reg <= m1_item_reg;
        q_item_reg  <= m2_item_reg;
        den_reg     <= den_next;
        num_reg     <= num_next;
    end

    // first quotient: s of the unclamped solution
    d1_tag_t         d1_in, d1_out;
    logic [XW1-1:0]  x1;
    logic            d1_valid;
    logic [QB-1:0]   q1;

    always_comb
    begin
        d1_in.item = q_item_reg;
        d1_in.zero = (den_reg == '0) || (num_reg <= 0);
        d1_in.one  = (num_reg >= den_reg);
        x1         = XW1'(num_reg[BIG_W-1:0]) << FB;
    end

    spcp_div #(.DW(BIG_W), .SW($bits(d1_tag_t))) u_div_main (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mv_reg[2]),
        .in_x      (x1),
        .in_d      (den_reg[BIG_W-1:0]),
        .in_tag    (d1_in),
        .out_valid (d1_valid),
        .out_q     (q1),
        .out_tag   (d1_out)
    );

    // t numerator b*s + f*one, then range test and the fallback s numerator
    logic [QB-1:0]   s_main;
    logic [2:0]      tv_reg;
    spcp_pkg::item_t t1_item_reg, t2_item_reg, t3_item_reg;
    logic [QB-1:0]   t1_s_reg, t2_s_reg, t3_s_reg;
    logic signed [DOT_W+QB:0] bs_reg, bs_next;
    logic signed [TN_W-1:0]   tn_reg, tn_next, t3_tn_reg, e_one;
    logic                     lt_next, gt_next, lt_reg, gt_reg;
    logic signed [NS_W-1:0]   ns_reg, ns_next;

    always_comb
    begin
        if (d1_out.zero)
            s_main = '0;
        else if (d1_out.one)
            s_main = spcp_pkg::PONE;
        else
            s_main = q1;
        bs_next = d1_out.item.b * $signed({1'b0, s_main});
        tn_next = TN_W'(bs_reg) + (TN_W'(t1_item_reg.f) <<< FB);
        e_one   = TN_W'(t2_item_reg.e) <<< FB;
        lt_next = (tn_reg < 0);
        gt_next = (tn_reg > e_one);
        if (!t2_item_reg.dege && gt_next)
            ns_next = NS_W'(t2_item_reg.b) - NS_W'(t2_item_reg.c);
        else
            ns_next = -NS_W'(t2_item_reg.c);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tv_reg <= '0;
        else
            tv_reg <= {tv_reg[1:0], d1_valid};
    end

    always_ff @(posedge clk)
    begin
        t1_item_reg <= d1_out.item;
        t1_s_reg    <= s_main;
        bs_reg      <= bs_next;
        t2_item_reg <= t1_item_reg;
        t2_s_reg    <= t1_s_reg;
        tn_reg      <= tn_next;
        t3_item_reg <= t2_item_reg;
        t3_s_reg    <= t2_s_reg;
        t3_tn_reg   <= tn_reg;
        lt_reg      <= lt_next;
        gt_reg      <= gt_next;
        ns_reg      <= ns_next;
    end

    // second pass: t over e and the fallback s over a, side by side
    dt_tag_t        dt_in, dt_out;
    ds_tag_t        ds_in, ds_out;
    logic [XW2-1:0] xt, xs;
    logic           dt_valid, ds_valid;
    logic [QB-1:0]  qt, qs;

    always_comb
    begin
        dt_in.item = t3_item_reg;
        dt_in.s    = t3_s_reg;
        dt_in.lt   = lt_reg;
        dt_in.gt   = gt_reg;
        if (t3_item_reg.dega)
        begin
            dt_in.zero = (t3_item_reg.f <= 0);
            dt_in.one  = (t3_item_reg.f >= t3_item_reg.e);
            xt         = XW2'(t3_item_reg.f[DOT_W-1:0]) << FB;
        end
        else
        begin
            dt_in.zero = 1'b0;
            dt_in.one  = 1'b0;
            xt         = t3_tn_reg[XW2-1:0];
        end
        ds_in.zero = (ns_reg <= 0);
        ds_in.one  = (ns_reg >= NS_W'(t3_item_reg.a));
        xs         = XW2'(ns_reg[DOT_W-1:0]) << FB;
    end

    spcp_div #(.DW(DOT_W), .SW($bits(dt_tag_t))) u_div_t (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (tv_reg[2]),
        .in_x      (xt),
        .in_d      (t3_item_reg.e[DOT_W-1:0]),
        .in_tag    (dt_in),
        .out_valid (dt_valid),
        .out_q     (qt),
        .out_tag   (dt_out)
    );

    spcp_div #(.DW(DOT_W), .SW($bits(ds_tag_t))) u_div_s (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (tv_reg[2]),
        .in_x      (xs),
        .in_d      (t3_item_reg.a[DOT_W-1:0]),
        .in_tag    (ds_in),
        .out_valid (ds_valid),
        .out_q     (qs),
        .out_tag   (ds_out)
    );

    logic [QB-1:0] s_alt, t_div, s_fin, t_fin;

    always_comb
    begin
        s_alt = ds_out.zero ? '0 : (ds_out.one ? spcp_pkg::PONE : qs);
        t_div = dt_out.zero ? '0 : (dt_out.one ? spcp_pkg::PONE : qt);
        if (dt_out.item.dega)
        begin
            s_fin = '0;
            t_fin = dt_out.item.dege ? '0 : t_div;
        end
        else if (dt_out.item.dege)
        begin
            s_fin = s_alt;
            t_fin = '0;
        end
        else if (dt_out.lt)
        begin
            s_fin = s_alt;
            t_fin = '0;
        end
        else if (dt_out.gt)
        begin
            s_fin = s_alt;
            t_fin = spcp_pkg::PONE;
        end
        else
        begin
            s_fin = dt_out.s;
            t_fin = t_div;
        end
    end

    spcp_pkg::cvec_t near_a, near_b;

    spcp_point u_point (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (dt_valid && ds_valid),
        .in_item  (dt_out.item),
        .in_s     (s_fin),
        .in_t     (t_fin),
        .eps      (eps_reg),
        .done     (done),
        .s_param  (s_param),
        .t_param  (t_param),
        .near_a   (near_a),
        .near_b   (near_b),
        .dist_sq  (dist_sq),
        .hit      (hit)
    );

    assign near_a_x = near_a[0];
    assign near_a_y = near_a[1];
    assign near_a_z = near_a[2];
    assign near_b_x = near_b[0];
    assign near_b_y = near_b[1];
    assign near_b_z = near_b[2];

    a_fixed_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("item did not come out after the pipeline latency");

    a_s_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (s_param <= spcp_pkg::PONE))
        else $error("s above one");

    a_t_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (t_param <= spcp_pkg::PONE))
        else $error("t above one");

    a_zero_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (done && dist_sq == '0) |-> hit)
        else $error("touching segments not flagged as hit");

endmodule
`default_nettype wire

>>> sim/tb_segment_pair_closest_points_core.sv
// testbench for the segment pair closest point core: random and directed items, self-checking
`timescale 1ns / 1ps
`default_nettype none
module tb_segment_pair_closest_points_core;

    localparam longint QONE = 65536;
    localparam int LATENCY = 49;

    // coordinates in port order: a start xyz, a end xyz, b start xyz, b end xyz
    typedef logic [11:0][15:0] seg_pair_t;

    typedef struct packed {
        logic [16:0]        s_param;
        logic [16:0]        t_param;
        logic signed [15:0] near_a_x;
        logic signed [15:0] near_a_y;
        logic signed [15:0] near_a_z;
        logic signed [15:0] near_b_x;
        logic signed [15:0] near_b_y;
        logic signed [15:0] near_b_z;
        logic [33:0]        dist_sq;
        logic               hit;
    } closest_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;
    seg_pair_t   coords;
    logic        done;
    closest_t    got;

    seg_pair_t   pending_pairs[$];
    closest_t    expected_points[$];
    logic [15:0] eps_now;
    int          mismatches;
    int          gap_left;
    int          quiet_mode;

    segment_pair_closest_points_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .a_start_x (coords[0]),
        .a_start_y (coords[1]),
        .a_start_z (coords[2]),
        .a_end_x   (coords[3]),
        .a_end_y   (coords[4]),
        .a_end_z   (coords[5]),
        .b_start_x (coords[6]),
        .b_start_y (coords[7]),
        .b_start_z (coords[8]),
        .b_end_x   (coords[9]),
        .b_end_y   (coords[10]),
        .b_end_z   (coords[11]),
        .done      (done),
        .s_param   (got.s_param),
        .t_param   (got.t_param),
        .near_a_x  (got.near_a_x),
        .near_a_y  (got.near_a_y),
        .near_a_z  (got.near_a_z),
        .near_b_x  (got.near_b_x),
        .near_b_y  (got.near_b_y),
        .near_b_z  (got.near_b_z),
        .dist_sq   (got.dist_sq),
        .hit       (got.hit)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // clamp(floor(num * 2^16 / den), 0, 1.0); den is positive
    function automatic longint clamped_quotient(input logic signed [127:0] num,
                                               input logic signed [127:0] den);
        logic signed [127:0] q;
        if (num <= 0) return 0;
        if (num >= den) return QONE;
        q = (num <<< 16) / den;
        return longint'(q);
    endfunction

    function automatic closest_t closest_points(input seg_pair_t p, input logic [15:0] eps_in);
        longint as[3], bs[3], d1[3], d2[3], rv[3], pa[3], pb[3];
        longint a, e, f, c, b, s, t, tn, df, eps;
        logic signed [127:0] den, num;
        longint dist_acc;
        closest_t res;
        eps = longint'(eps_in);
        for (int i = 0; i < 3; i++)
        begin
            as[i] = longint'($signed(p[i]));
            d1[i] = longint'($signed(p[3 + i])) - as[i];
            bs[i] = longint'($signed(p[6 + i]));
            d2[i] = longint'($signed(p[9 + i])) - bs[i];
            rv[i] = as[i] - bs[i];
        end
        a = d1[0] * d1[0] + d1[1] * d1[1] + d1[2] * d1[2];
        e = d2[0] * d2[0] + d2[1] * d2[1] + d2[2] * d2[2];
        f = d2[0] * rv[0] + d2[1] * rv[1] + d2[2] * rv[2];
        c = d1[0] * rv[0] + d1[1] * rv[1] + d1[2] * rv[2];
        b = d1[0] * d2[0] + d1[1] * d2[1] + d1[2] * d2[2];
        s = 0;
        t = 0;
        if (a <= eps && e <= eps)
        begin
            s = 0;
            t = 0;
        end
        else if (a <= eps)
            t = clamped_quotient(f, e);
        else if (e <= eps)
            s = clamped_quotient(-c, a);
        else
        begin
            den = 128'(a) * 128'(e) - 128'(b) * 128'(b);
            num = 128'(b) * 128'(f) - 128'(c) * 128'(e);
            // parallel segments: pin s to the start of a
            s = (den != 0) ? clamped_quotient(num, den) : 0;
            tn = b * s + f * QONE;
            if (tn < 0)
            begin
                t = 0;
                s = clamped_quotient(-c, a);
            end
            else if (tn > e * QONE)
            begin
                t = QONE;
                s = clamped_quotient(b - c, a);
            end
            else
                t = tn / e;
        end
        dist_acc = 0;
        for (int i = 0; i < 3; i++)
        begin
            // round half up: arithmetic shift floors
            pa[i] = (as[i] * QONE + d1[i] * s + QONE / 2) >>> 16;
            pb[i] = (bs[i] * QONE + d2[i] * t + QONE / 2) >>> 16;
            df = pa[i] - pb[i];
            dist_acc += df * df;
        end
        res.s_param  = 17'(s);
        res.t_param  = 17'(t);
        res.near_a_x = 16'(pa[0]);
        res.near_a_y = 16'(pa[1]);
        res.near_a_z = 16'(pa[2]);
        res.near_b_x = 16'(pb[0]);
        res.near_b_y = 16'(pb[1]);
        res.near_b_z = 16'(pb[2]);
        res.dist_sq  = 34'(dist_acc);
        res.hit      = (dist_acc <= eps) ? 1'b1 : 1'b0;
        return res;
    endfunction

    function automatic int next_gap();
        int roll;
        roll = $urandom_range(99);
        if (quiet_mode != 0 || roll < 50) return 0;
        if (roll < 92) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // driver: one item per start/busy handshake
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start    <= 1'b0;
            coords   <= '0;
            gap_left <= 0;
        end
        else
        begin
            logic      go;
            int        gap;
            seg_pair_t nxt;
            go  = start;
            gap = gap_left;
            nxt = coords;
            if (start && !busy)
            begin
                expected_points.push_back(closest_points(coords, eps_now));
                go  = 1'b0;
                gap = next_gap();
            end
            if (!go)
            begin
                if (gap > 0)
                    gap = gap - 1;
                else if (pending_pairs.size() > 0)
                begin
                    nxt = pending_pairs.pop_front();
                    go  = 1'b1;
                end
            end
            start    <= go;
            coords   <= nxt;
            gap_left <= gap;
        end
    end

    // monitor: results cannot be held off, so each strobe is checked as it comes
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            closest_t want;
            if (expected_points.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: %p", got);
            end
            else
            begin
                want = expected_points.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p got %p", want, got);
                end
            end
        end
    end

    function automatic logic [15:0] rand_coord(input int span);
        if (span == 0) return 16'($urandom);
        return 16'($signed($urandom_range(2 * span, 0)) - span);
    endfunction

    function automatic seg_pair_t rand_pair();
        seg_pair_t p;
        int span, roll;
        roll = $urandom_range(99);
        span = (roll < 30) ? 0 : (roll < 60) ? 2000 : (roll < 85) ? 60 : 3;
        for (int i = 0; i < 12; i++)
            p[i] = rand_coord(span);
        roll = $urandom_range(99);
        // shape some pairs: degenerate ends, parallel and shared points
        if (roll < 8)
            p[5:3] = p[2:0];
        else if (roll < 16)
            p[11:9] = p[8:6];
        else if (roll < 22)
            for (int i = 0; i < 3; i++)
                p[9 + i] = p[6 + i] + (p[3 + i] - p[i]);
        else if (roll < 26)
            p[8:6] = p[5:3];
        return p;
    endfunction

    function automatic seg_pair_t mk(input int ax, ay, az, bx, by, bz,
                                     input int cx, cy, cz, dx, dy, dz);
        seg_pair_t p;
        p[0] = 16'(ax); p[1] = 16'(ay); p[2] = 16'(az);
        p[3] = 16'(bx); p[4] = 16'(by); p[5] = 16'(bz);
        p[6] = 16'(cx); p[7] = 16'(cy); p[8] = 16'(cz);
        p[9] = 16'(dx); p[10] = 16'(dy); p[11] = 16'(dz);
        return p;
    endfunction

    task automatic wait_idle();
        while (pending_pairs.size() > 0 || start || expected_points.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    task automatic write_eps(input logic [15:0] val);
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        eps_now   = val;
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        logic [15:0] eps_set[5];
        mismatches = 0;
        quiet_mode = 0;
        eps_now    = '0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        rst_n      = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed items at reset eps of zero
        pending_pairs.push_back(mk(0, 0, 0, 0, 0, 0, 5, 5, 5, 5, 5, 5));
        pending_pairs.push_back(mk(3, 4, 5, 3, 4, 5, -10, 0, 0, 10, 0, 0));
        pending_pairs.push_back(mk(-10, 0, 0, 10, 0, 0, 7, 7, 7, 7, 7, 7));
        pending_pairs.push_back(mk(0, 0, 0, 10, 0, 0, 0, 5, 0, 10, 5, 0));
        pending_pairs.push_back(mk(-10, 0, 0, 10, 0, 0, 0, -10, 3, 0, 10, 3));
        pending_pairs.push_back(mk(0, 0, 0, 10, 0, 0, -20, -5, 0, -15, 5, 0));
        pending_pairs.push_back(mk(0, 0, 0, 10, 0, 0, 30, -5, 0, 25, 5, 0));
        pending_pairs.push_back(mk(0, 0, 0, 1, 0, 0, 0, 3, 0, 0, 100, 0));
        pending_pairs.push_back(mk(0, 0, 0, 1, 1, 0, 1, 0, 0, 0, 1, 7));
        pending_pairs.push_back(mk(-32768, -32768, -32768, 32767, 32767, 32767,
                                   32767, -32768, 32767, -32768, 32767, -32768));
        pending_pairs.push_back(mk(-32768, -32768, -32768, 32767, 32767, 32767,
                                   -32768, -32768, -32768, 32767, 32767, 32767));
        pending_pairs.push_back(mk(-32768, -32768, -32768, -32768, -32768, -32768,
                                   32767, 32767, 32767, 32767, 32767, 32767));
        pending_pairs.push_back(mk(32767, 0, -32768, -32768, 0, 32767,
                                   0, 32767, 0, 0, -32768, 0));
        pending_pairs.push_back(mk(-1, -1, -1, -1, -1, -1, 0, 0, 0, 0, 0, 0));
        pending_pairs.push_back(mk(0, 0, 0, 3, 0, 0, 0, 1, 0, 0, 1, 0));
        wait_idle();

        eps_set[0] = 16'd65535;
        eps_set[1] = 16'd3;
        eps_set[2] = 16'($urandom);
        eps_set[3] = 16'd0;
        eps_set[4] = 16'd200;
        for (int ph = 0; ph < 5; ph++)
        begin
            write_eps(eps_set[ph]);
            quiet_mode = (ph == 2) ? 1 : 0;
            // small eps-sized segments so the degenerate paths trigger when eps is large enough
            pending_pairs.push_back(mk(0, 0, 0, 1, 1, 1, 5, 0, 0, 5, 2, 0));
            for (int n = 0; n < 80; n++)
                pending_pairs.push_back(rand_pair());
            wait_idle();
        end

        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #(2_000_000);
        $display("end of test: mismatches");
        $finish;
    end

endmodule
`default_nettype wire
